@@ rtl/ifvd_pkg.sv @@
// ----------------------------------------------------------------------------
// ifvd_pkg
// shared types and constants for the ir flame vote detector
// ----------------------------------------------------------------------------
package ifvd_pkg;

  localparam int NUM_CHANNELS = 5;
  localparam int SAMPLE_W     = 12;
  localparam int ALPHA_W      = 16;
  localparam int MARGIN_W     = 12;
  localparam int VERIFY_W     = 16;
  localparam int AMB_W        = 3;
  localparam int TIME_W       = 32;
  localparam int TOTAL_W      = $clog2(NUM_CHANNELS + 1);
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  localparam logic [AMB_W-1:0]    AMB_RESET    = 3'd4;
  localparam logic [MARGIN_W-1:0] MARGIN_RESET = 12'd100;
  localparam logic [ALPHA_W-1:0]  ALPHA_RESET  = 16'd655;
  localparam logic [VERIFY_W-1:0] VERIFY_RESET = 16'd500;

  typedef enum logic [1:0] {
    ST_IDLE      = 2'd0,
    ST_POTENTIAL = 2'd1,
    ST_DETECTED  = 2'd2,
    ST_AMBIENT   = 2'd3
  } det_state_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPIKE_MARGIN = 2'd0,
    REG_SMOOTH_GAIN  = 2'd1,
    REG_VERIFY_MS    = 2'd2,
    REG_AMBIENT_MIN  = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_CLEAR  = 1'b1
  } req_t;

  typedef struct packed {
    logic                req_type;
    logic [SAMPLE_W-1:0] sample_ch0;
    logic [SAMPLE_W-1:0] sample_ch1;
    logic [SAMPLE_W-1:0] sample_ch2;
    logic [SAMPLE_W-1:0] sample_ch3;
    logic [SAMPLE_W-1:0] sample_ch4;
    logic [TIME_W-1:0]   time_ms;
  } in_word_t;

  typedef struct packed {
    logic [1:0]              detect_state;
    logic                    flame_flag;
    logic [NUM_CHANNELS-1:0] spike_mask;
    logic [TOTAL_W-1:0]      spike_total;
  } out_word_t;

  // per-item control from the top level to the datapath parts
  typedef struct packed {
    logic en;
    logic clr;
  } step_ctl_t;

endpackage

@@ rtl/ifvd_channel.sv @@
// ----------------------------------------------------------------------------
// ifvd_channel
// one channel: ema baseline register, update and spike compare
// ----------------------------------------------------------------------------
module ifvd_channel #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  ifvd_pkg::step_ctl_t            ctl,
  input  logic [ifvd_pkg::SAMPLE_W-1:0]  sample,
  input  logic [ifvd_pkg::ALPHA_W-1:0]   alpha,
  input  logic [ifvd_pkg::MARGIN_W-1:0]  margin,
  output logic                           spike
);

  localparam int BW = ifvd_pkg::SAMPLE_W + FRAC_BITS;
  localparam int DW = BW + 1;
  localparam int PW = DW + ifvd_pkg::ALPHA_W + 1;
  localparam int NW = BW + 2;

  logic [BW-1:0]        baseline;
  logic [BW-1:0]        baseline_next;
  logic [BW-1:0]        s_fx;
  logic signed [DW-1:0] diff_in;
  logic signed [PW-1:0] prod;
  logic signed [NW-1:0] delta;
  logic signed [NW-1:0] nb_wide;
  logic signed [NW-1:0] diff_out;
  logic signed [NW-1:0] margin_fx;

  always_comb begin
    s_fx    = {sample, {FRAC_BITS{1'b0}}};
    diff_in = $signed({1'b0, s_fx}) - $signed({1'b0, baseline});
    prod    = diff_in * $signed({1'b0, alpha});
    // arithmetic shift floors toward minus infinity
    delta   = NW'(prod >>> ifvd_pkg::ALPHA_W);
    nb_wide = $signed({2'b00, baseline}) + delta;
    if (nb_wide < 0) begin
      baseline_next = '0;
    end else if (nb_wide > $signed({2'b00, {BW{1'b1}}})) begin
      baseline_next = '1;
    end else begin
      baseline_next = nb_wide[BW-1:0];
    end
    diff_out  = $signed({2'b00, s_fx}) - $signed({2'b00, baseline_next});
    margin_fx = $signed({2'b00, margin, {FRAC_BITS{1'b0}}});
    spike     = diff_out > margin_fx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      baseline <= '0;
    end else if (ctl.en) begin
      baseline <= ctl.clr ? '0 : baseline_next;
    end
  end

endmodule

@@ rtl/ifvd_vote.sv @@
// ----------------------------------------------------------------------------
// ifvd_vote
// spike vote state machine with persistence timer
// ----------------------------------------------------------------------------
module ifvd_vote (
  input  logic                                clk,
  input  logic                                rst,
  input  ifvd_pkg::step_ctl_t                 ctl,
  input  logic [ifvd_pkg::NUM_CHANNELS-1:0]   mask,
  input  logic [ifvd_pkg::TIME_W-1:0]         now,
  input  logic [ifvd_pkg::VERIFY_W-1:0]       verify_ms,
  input  logic [ifvd_pkg::AMB_W-1:0]          ambient_min,
  output ifvd_pkg::out_word_t                 result
);

  ifvd_pkg::det_state_t              state;
  ifvd_pkg::det_state_t              state_next;
  ifvd_pkg::det_state_t              state_mid;
  logic [ifvd_pkg::TIME_W-1:0]       start_stamp;
  logic [ifvd_pkg::TIME_W-1:0]       start_stamp_next;
  logic                              start_valid;
  logic                              start_valid_next;
  logic [ifvd_pkg::TOTAL_W-1:0]      total;
  logic                              adjacent;
  logic [ifvd_pkg::TIME_W-1:0]       elapsed;

  always_comb begin
    total = '0;
    for (int i = 0; i < ifvd_pkg::NUM_CHANNELS; i++) begin
      total = total + ifvd_pkg::TOTAL_W'(mask[i]);
    end
    adjacent = |(mask & (mask >> 1));
  end

  // next state
  always_comb begin
    state_mid        = state;
    start_stamp_next = start_stamp;
    start_valid_next = start_valid;
    priority if (total == '0) begin
      if (state == ifvd_pkg::ST_POTENTIAL) begin
        state_mid        = ifvd_pkg::ST_IDLE;
        start_valid_next = 1'b0;
        start_stamp_next = '0;
      end
    end else if (ifvd_pkg::TOTAL_W'(ambient_min) <= total) begin
      state_mid        = ifvd_pkg::ST_AMBIENT;
      start_valid_next = 1'b0;
      start_stamp_next = '0;
    end else if (total == ifvd_pkg::TOTAL_W'(1) ||
                 (total == ifvd_pkg::TOTAL_W'(2) && adjacent)) begin
      state_mid = ifvd_pkg::ST_POTENTIAL;
      if (!start_valid) begin
        start_stamp_next = now;
        start_valid_next = 1'b1;
      end
    end else begin
      state_mid = state;
    end
    elapsed    = now - start_stamp_next;
    state_next = state_mid;
    if (state_mid == ifvd_pkg::ST_POTENTIAL &&
        elapsed >= ifvd_pkg::TIME_W'(verify_ms)) begin
      state_next = ifvd_pkg::ST_DETECTED;
    end
    if (ctl.clr) begin
      state_next       = ifvd_pkg::ST_IDLE;
      start_stamp_next = '0;
      start_valid_next = 1'b0;
    end
  end

  // outputs
  always_comb begin
    result.detect_state = state_next;
    result.flame_flag   = state_next == ifvd_pkg::ST_DETECTED;
    result.spike_mask   = ctl.clr ? '0 : mask;
    result.spike_total  = ctl.clr ? '0 : total;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ifvd_pkg::ST_IDLE;
      start_stamp <= '0;
      start_valid <= 1'b0;
    end else if (ctl.en) begin
      state       <= state_next;
      start_stamp <= start_stamp_next;
      start_valid <= start_valid_next;
    end
  end

endmodule

@@ rtl/ir_flame_vote_detector.sv @@
// ----------------------------------------------------------------------------
// ir_flame_vote_detector
// ema baseline spike detector over five ir channels with a vote state machine
// ----------------------------------------------------------------------------
// a word accepted into the input register passes the channels and vote logic into the result register
// throughput: one word per cycle while the output is not stalled, set by the baseline update
// while a result waits to be taken, the input register holds one word and then stalls the input side
// reset: synchronous, clears baselines, vote state and valid flags, loads config register defaults
module ir_flame_vote_detector #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [ifvd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ifvd_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  ifvd_pkg::in_word_t                in_word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output ifvd_pkg::out_word_t               out_word
);

  logic [ifvd_pkg::MARGIN_W-1:0]     spike_margin;
  logic [ifvd_pkg::ALPHA_W-1:0]      smooth_gain;
  logic [ifvd_pkg::VERIFY_W-1:0]     verify_ms;
  logic [ifvd_pkg::AMB_W-1:0]        ambient_min;

  ifvd_pkg::in_word_t                in_q;
  logic                              in_full;
  logic                              advance;
  ifvd_pkg::step_ctl_t               ctl;
  logic [ifvd_pkg::NUM_CHANNELS-1:0] mask;
  logic [ifvd_pkg::SAMPLE_W-1:0]     samples [ifvd_pkg::NUM_CHANNELS];
  ifvd_pkg::out_word_t               result;

  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;
  assign ctl.en   = advance;
  assign ctl.clr  = in_q.req_type == ifvd_pkg::REQ_CLEAR;

  assign samples[0] = in_q.sample_ch0;
  assign samples[1] = in_q.sample_ch1;
  assign samples[2] = in_q.sample_ch2;
  assign samples[3] = in_q.sample_ch3;
  assign samples[4] = in_q.sample_ch4;

  always_ff @(posedge clk) begin
    if (rst) begin
      spike_margin <= ifvd_pkg::MARGIN_RESET;
      smooth_gain  <= ifvd_pkg::ALPHA_RESET;
      verify_ms    <= ifvd_pkg::VERIFY_RESET;
      ambient_min  <= ifvd_pkg::AMB_RESET;
    end else if (cfg_wr_en) begin
      unique case (ifvd_pkg::cfg_idx_t'(cfg_index))
        ifvd_pkg::REG_SPIKE_MARGIN: spike_margin <= cfg_data[ifvd_pkg::MARGIN_W-1:0];
        ifvd_pkg::REG_SMOOTH_GAIN:  smooth_gain  <= cfg_data[ifvd_pkg::ALPHA_W-1:0];
        ifvd_pkg::REG_VERIFY_MS:    verify_ms    <= cfg_data[ifvd_pkg::VERIFY_W-1:0];
        ifvd_pkg::REG_AMBIENT_MIN:  ambient_min  <= cfg_data[ifvd_pkg::AMB_W-1:0];
        default:                    ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q <= in_word;
    end
  end

  for (genvar g = 0; g < ifvd_pkg::NUM_CHANNELS; g++) begin : g_ch
    ifvd_channel #(
      .FRAC_BITS (FRAC_BITS)
    ) u_channel (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl),
      .sample (samples[g]),
      .alpha  (smooth_gain),
      .margin (spike_margin),
      .spike  (mask[g])
    );
  end

  ifvd_vote u_vote (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .mask        (mask),
    .now         (in_q.time_ms),
    .verify_ms   (verify_ms),
    .ambient_min (ambient_min),
    .result      (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= result;
    end
  end

endmodule

@@ rtl/ifvd_checker.sv @@
// ----------------------------------------------------------------------------
// ifvd_checker
// port-level checks on the ir flame vote detector
// ----------------------------------------------------------------------------
module ifvd_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_stall,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  ifvd_pkg::out_word_t  out_word
);

  // flag follows the reported state
  a_flag_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.flame_flag ==
                   (out_word.detect_state == ifvd_pkg::ST_DETECTED)))
    else $error("flame_flag disagrees with detect_state");

  // count agrees with the mask
  a_total_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.spike_total == $countones(out_word.spike_mask)))
    else $error("spike_total disagrees with spike_mask");

  // a held result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_word)))
    else $error("stalled result word changed");

  // pipeline empties on reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("pipeline not empty after reset");

endmodule

bind ir_flame_vote_detector ifvd_checker u_ifvd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
